@@ rtl/ktde_pkg.sv @@
package ktde_pkg;

	localparam int ROOT_STEPS = 32;
	localparam int DIV_STEPS  = 48;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ADDR_II = 2'd0,
		ADDR_JJ = 2'd1,
		ADDR_IJ = 2'd2
	} addr_sel_t;

	typedef enum logic [1:0] {
		RES_ZERO  = 2'd0,
		RES_DEGEN = 2'd1,
		RES_SAT   = 2'd2,
		RES_ROOT  = 2'd3
	} res_sel_t;

	typedef enum logic {
		SQ_SRC_PROD = 1'b0,
		SQ_SRC_RAD  = 1'b1
	} sq_src_t;

	typedef struct packed {
		logic      capture;
		logic      wr;
		addr_sel_t addr_sel;
		logic      ld_dii;
		logic      ld_djj;
		logic      ld_kij;
		logic      ld_prod;
		logic      ld_rad_raw;
		logic      ld_rad_norm;
		logic      sqrt_start;
		sq_src_t   sqrt_src;
		logic      div_start;
		logic      res_ld;
		res_sel_t  res_sel;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic is_query;
		logic in_range;
		logic prod_nonpos;
		logic sqrt_done;
		logic div_done;
		logic rad_nonpos;
		logic rad_sat;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/ktde_ram.sv @@
module ktde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/ktde_sqrt.sv @@
module ktde_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic [31:0] root,
	output logic        done
);
	import ktde_pkg::*;

	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] rem_sh;
	logic [33:0] trial;
	logic        ge;

	assign rem_sh = {rem_q[31:0], x_q[63:62]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(ROOT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[61:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[30:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

@@ rtl/ktde_dp.sv @@
module ktde_dp #(
	parameter int MAX_SIZE = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [39:0]     s_tdata,
	input  logic            s_tuser,
	input  ktde_pkg::cmd_t  cmd,
	output ktde_pkg::stat_t stat,
	output logic [31:0]     m_tdata,
	output logic            m_tuser,
	output logic            m_tvalid,
	input  logic            m_tready
);
	import ktde_pkg::*;

	localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);

	logic               kind_q;
	logic [3:0]         row_q;
	logic [3:0]         col_q;
	logic [31:0]        val_q;
	logic [3:0]         r_sel;
	logic [3:0]         c_sel;
	logic [AW-1:0]      addr;
	logic [31:0]        rdata;
	logic signed [31:0] dii_q;
	logic signed [31:0] djj_q;
	logic signed [31:0] kij_q;
	logic signed [63:0] prod_q;
	logic signed [50:0] rad_q;
	logic [63:0]        sq_in;
	logic [31:0]        sq_root;
	logic               sq_done;
	logic [31:0]        kij_mag;
	logic [47:0]        dvd_q;
	logic [31:0]        drem_q;
	logic [31:0]        dvsr_q;
	logic               dneg_q;
	logic [5:0]         dcnt_q;
	logic               dbusy_q;
	logic               ddone_q;
	logic [32:0]        drem_sh;
	logic               dge;
	logic [49:0]        q_signed;
	logic signed [50:0] s_term;
	logic [31:0]        res_dist_q;
	logic               res_degen_q;
	logic [31:0]        dist_q;
	logic               degen_q;
	logic               mvalid_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= s_tuser;
			row_q  <= s_tdata[3:0];
			col_q  <= s_tdata[7:4];
			val_q  <= s_tdata[39:8];
		end
	end

	always_comb begin
		case (cmd.addr_sel)
			ADDR_II: begin
				r_sel = row_q;
				c_sel = row_q;
			end
			ADDR_JJ: begin
				r_sel = col_q;
				c_sel = col_q;
			end
			default: begin
				r_sel = row_q;
				c_sel = col_q;
			end
		endcase
	end

	assign addr = AW'(32'(r_sel) * MAX_SIZE + 32'(c_sel));

	ktde_ram #(
		.WIDTH(32),
		.DEPTH(MAX_SIZE * MAX_SIZE)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr),
		.addr (addr),
		.wdata(val_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.ld_dii) begin
			dii_q <= rdata;
		end
		if (cmd.ld_djj) begin
			djj_q <= rdata;
		end
		if (cmd.ld_kij) begin
			kij_q <= rdata;
		end
		if (cmd.ld_prod) begin
			prod_q <= dii_q * djj_q;
		end
		if (cmd.ld_rad_raw) begin
			rad_q <= 51'(dii_q) + 51'(djj_q) - (51'(kij_q) <<< 1);
		end else if (cmd.ld_rad_norm) begin
			rad_q <= s_term - $signed({q_signed, 1'b0});
		end
	end

	assign sq_in = (cmd.sqrt_src == SQ_SRC_PROD) ? prod_q : {rad_q[47:0], 16'h0000};

	ktde_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.sqrt_start),
		.radicand(sq_in),
		.root    (sq_root),
		.done    (sq_done)
	);

	assign kij_mag = kij_q[31] ? 32'(-kij_q) : kij_q;
	assign drem_sh = {drem_q, dvd_q[47]};
	assign dge     = drem_sh >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= '0;
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q + 6'd1;
				if (dcnt_q == 6'(DIV_STEPS - 1)) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q  <= {kij_mag, 16'h0000};
			drem_q <= '0;
			dvsr_q <= sq_root;
			dneg_q <= kij_q[31];
		end else if (dbusy_q) begin
			drem_q <= dge ? 32'(drem_sh - {1'b0, dvsr_q}) : drem_sh[31:0];
			dvd_q  <= {dvd_q[46:0], dge};
		end
	end

	assign q_signed = dneg_q ? 50'(-{2'b00, dvd_q}) : {2'b00, dvd_q};
	assign s_term   = dii_q[31] ? -51'sd131072 : 51'sd131072;

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			case (cmd.res_sel)
				RES_DEGEN: begin
					res_dist_q  <= '0;
					res_degen_q <= 1'b1;
				end
				RES_SAT: begin
					res_dist_q  <= '1;
					res_degen_q <= 1'b0;
				end
				RES_ROOT: begin
					res_dist_q  <= sq_root;
					res_degen_q <= 1'b0;
				end
				default: begin
					res_dist_q  <= '0;
					res_degen_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			dist_q  <= res_dist_q;
			degen_q <= res_degen_q;
		end
	end

	assign stat.is_query    = kind_q == KIND_QUERY;
	assign stat.in_range    = (32'(row_q) < MAX_SIZE) && (32'(col_q) < MAX_SIZE);
	assign stat.prod_nonpos = prod_q[63] || (prod_q == '0);
	assign stat.sqrt_done   = sq_done;
	assign stat.div_done    = ddone_q;
	assign stat.rad_nonpos  = rad_q[50] || (rad_q == '0);
	assign stat.rad_sat     = !rad_q[50] && (rad_q[49:48] != 2'b00);
	assign stat.out_free    = !mvalid_q || m_tready;

	assign m_tdata  = dist_q;
	assign m_tuser  = degen_q;
	assign m_tvalid = mvalid_q;

endmodule

@@ rtl/ktde_ctrl.sv @@
module ktde_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            norm,
	input  ktde_pkg::stat_t stat,
	output ktde_pkg::cmd_t  cmd
);
	import ktde_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_CHECK  = 11'b00000000010,
		ST_RD_JJ  = 11'b00000000100,
		ST_RD_IJ  = 11'b00000001000,
		ST_MUL    = 11'b00000010000,
		ST_DECIDE = 11'b00000100000,
		ST_SQ_P   = 11'b00001000000,
		ST_DIV    = 11'b00010000000,
		ST_CHK_R  = 11'b00100000000,
		ST_SQ_R   = 11'b01000000000,
		ST_DONE   = 11'b10000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.addr_sel = ADDR_IJ;
		cmd.res_sel  = RES_ZERO;
		cmd.sqrt_src = SQ_SRC_PROD;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!stat.is_query) begin
					cmd.wr  = stat.in_range;
					state_d = ST_IDLE;
				end else if (!stat.in_range) begin
					cmd.res_ld = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.addr_sel = ADDR_II;
					state_d = ST_RD_JJ;
				end
			end
			ST_RD_JJ: begin
				cmd.addr_sel = ADDR_JJ;
				cmd.ld_dii   = 1'b1;
				state_d = ST_RD_IJ;
			end
			ST_RD_IJ: begin
				cmd.ld_djj = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.ld_kij  = 1'b1;
				cmd.ld_prod = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!norm) begin
					cmd.ld_rad_raw = 1'b1;
					state_d = ST_CHK_R;
				end else if (stat.prod_nonpos) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_DEGEN;
					state_d = ST_DONE;
				end else begin
					cmd.sqrt_start = 1'b1;
					state_d = ST_SQ_P;
				end
			end
			ST_SQ_P: begin
				if (stat.sqrt_done) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.ld_rad_norm = 1'b1;
					state_d = ST_CHK_R;
				end
			end
			ST_CHK_R: begin
				cmd.sqrt_src = SQ_SRC_RAD;
				if (stat.rad_nonpos) begin
					cmd.res_ld = 1'b1;
					state_d = ST_DONE;
				end else if (stat.rad_sat) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_SAT;
					state_d = ST_DONE;
				end else begin
					cmd.sqrt_start = 1'b1;
					state_d = ST_SQ_R;
				end
			end
			ST_SQ_R: begin
				if (stat.sqrt_done) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_ROOT;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/kernel_to_distance_engine_unit.sv @@
// Kernel matrix store with a distance query engine. A load request (tuser 0) writes one
// signed Q16.16 kernel entry if both indices are below MAX_SIZE. A query request (tuser 1)
// returns one unsigned Q16.16 distance with a degenerate flag in tuser. The result is
// presented once the shared bit-per-cycle square root unit (32 steps, used twice when
// normalised) and, for a normalised query, the 48-step restoring divider have finished. A
// normalised query with a non-positive diagonal product answers with the degenerate flag,
// a query with an index at or beyond MAX_SIZE or a non-positive radicand answers 0, and one
// whose radicand is too large answers all ones. The next request is taken in the cycle after
// the result is loaded into the output register, where it waits for the sink; a result still
// waiting there holds the following query in its last step.
module kernel_to_distance_engine_unit #(
	parameter int MAX_SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // row_index[3:0], col_index[7:4], kernel_value[39:8]
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // distance
	output logic        m_tuser,  // degenerate
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);
	import ktde_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  norm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q <= 1'b1;
		end else if (cfg_wr_en) begin
			norm_q <= cfg_wr_data;
		end
	end

	ktde_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.norm    (norm_q),
		.stat    (stat),
		.cmd     (cmd)
	);

	ktde_dp #(
		.MAX_SIZE(MAX_SIZE)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.stat    (stat),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate result with nonzero distance");

	a_degen_norm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> norm_q)
		else $error("degenerate result with normalisation off");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while previous one in flight");

endmodule
